>>> src/assert_macros.svh
// Assertion macros shared by the SHA-1 digest RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define SHA1MD_ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Checks that a consequent holds in the cycle where an antecedent is seen.
`define SHA1MD_ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

>>> src/sha1md_pkg.sv
// Shared types and constants of the SHA-1 message digest block.
package sha1md_pkg;

  typedef logic [31:0] word_t;
  typedef logic [4:0][31:0] hash_t;

  typedef enum logic [1:0] {
    STAGE_CH,
    STAGE_PAR1,
    STAGE_MAJ,
    STAGE_PAR2
  } stage_t;

  localparam hash_t INIT_CHAIN = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  localparam logic [31:0] K_CH   = 32'h5A827999;
  localparam logic [31:0] K_PAR1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJ  = 32'h8F1BBCDC;
  localparam logic [31:0] K_PAR2 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_MARK  = 8'h80;
  localparam logic [5:0] LEN_START = 6'd56;
  localparam logic [5:0] FILL_LAST = 6'd63;
  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [2:0] WORD_LAST = 3'd4;

endpackage

>>> src/sha1_message_digest.sv
// Top level of the SHA-1 message digest: byte intake, padding and round sequencer.
// Message bytes are taken one per cycle on the slave side while a 64-byte block
// fills; the transfer that completes a block starts a compression (80 rounds
// through one shared round unit, then the chaining add), during which s_tready
// is low. The transfer marked with s_tlast starts padding, which feeds the 0x80
// byte, zeros and the 64-bit bit count one byte per cycle through the same path,
// with one more compression in between when the padding spills into a second
// block. The digest then leaves as five 32-bit transfers, word 0 first, and the
// block returns to its initial values for the next message.
`include "assert_macros.svh"

module sha1_message_digest
  import sha1md_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // data_byte
  input  logic [0:0]  s_tuser,   // byte_present
  input  logic        s_tlast,   // message_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // digest_word
  output logic [2:0]  m_tuser,   // word_index
  output logic        m_tlast    // last_word
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_MARK,
    PH_ZERO,
    PH_LEN
  } phase_t;

  state_t      state;
  phase_t      phase;
  logic        pad_active;
  logic [5:0]  fill_count;
  logic [63:0] bit_length;
  logic [6:0]  round_count;
  logic [2:0]  out_idx;
  logic [23:0] acc;
  hash_t       chain;

  logic        accept;
  logic        put_en;
  logic [7:0]  put_data;
  logic [2:0]  len_sel;
  logic        wrap;
  logic        push;
  word_t       push_word;
  stage_t      stage;
  word_t       w_cur;
  hash_t       regs;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign len_sel  = 3'd7 - fill_count[2:0];

  always_comb begin
    put_en   = 1'b0;
    put_data = s_tdata;
    case (state)
      ST_IDLE: begin
        put_en   = accept && s_tuser[0];
        put_data = s_tdata;
      end
      ST_PAD: begin
        put_en = 1'b1;
        if (phase == PH_MARK) begin
          put_data = PAD_MARK;
        end else if (phase == PH_ZERO && fill_count != LEN_START) begin
          put_data = '0;
        end else begin
          put_data = bit_length[{len_sel, 3'b000} +: 8];
        end
      end
      default: begin
        put_en = 1'b0;
      end
    endcase
  end

  assign push      = put_en && (fill_count[1:0] == 2'd3);
  assign push_word = {acc, put_data};
  assign wrap      = put_en && (fill_count == FILL_LAST);

  always_comb begin
    if (round_count < 7'd20) begin
      stage = STAGE_CH;
    end else if (round_count < 7'd40) begin
      stage = STAGE_PAR1;
    end else if (round_count < 7'd60) begin
      stage = STAGE_MAJ;
    end else begin
      stage = STAGE_PAR2;
    end
  end

  sha1md_sched u_sched (
    .clk       (clk),
    .push      (push),
    .push_word (push_word),
    .step      (state == ST_ROUND),
    .w_cur     (w_cur)
  );

  sha1md_round u_round (
    .clk   (clk),
    .rst   (rst),
    .load  (wrap),
    .step  (state == ST_ROUND),
    .stage (stage),
    .chain (chain),
    .w     (w_cur),
    .regs  (regs)
  );

  always_ff @(posedge clk) begin
    if (put_en && fill_count[1:0] != 2'd3) begin
      acc <= {acc[15:0], put_data};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      phase       <= PH_MARK;
      pad_active  <= 1'b0;
      fill_count  <= '0;
      bit_length  <= '0;
      round_count <= '0;
      out_idx     <= '0;
      chain       <= INIT_CHAIN;
    end else begin
      if (put_en) begin
        fill_count <= fill_count + 6'd1;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (s_tuser[0]) begin
              bit_length <= bit_length + 64'd8;
            end
            if (s_tlast) begin
              pad_active <= 1'b1;
              phase      <= PH_MARK;
            end
            if (wrap) begin
              state <= ST_ROUND;
            end else if (s_tlast) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          if (phase == PH_MARK) begin
            phase <= PH_ZERO;
          end else if (phase == PH_ZERO && fill_count == LEN_START) begin
            phase <= PH_LEN;
          end
          if (wrap) begin
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          if (round_count == ROUND_LAST) begin
            round_count <= '0;
            state       <= ST_ADD;
          end else begin
            round_count <= round_count + 7'd1;
          end
        end
        ST_ADD: begin
          for (int i = 0; i < 5; i++) begin
            chain[i] <= chain[i] + regs[i];
          end
          if (pad_active && phase == PH_LEN) begin
            out_idx <= '0;
            state   <= ST_OUT;
          end else if (pad_active) begin
            state <= ST_PAD;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_OUT: begin
          if (m_tready) begin
            if (out_idx == WORD_LAST) begin
              chain      <= INIT_CHAIN;
              bit_length <= '0;
              pad_active <= 1'b0;
              phase      <= PH_MARK;
              out_idx    <= '0;
              state      <= ST_IDLE;
            end else begin
              out_idx <= out_idx + 3'd1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tvalid = (state == ST_OUT);
  assign m_tdata  = chain[out_idx];
  assign m_tuser  = out_idx;
  assign m_tlast  = (out_idx == WORD_LAST);

  `SHA1MD_ASSERT_ALWAYS(a_no_overlap, clk, rst, !(s_tready && m_tvalid), "intake and digest output overlap")
  `SHA1MD_ASSERT_IMPLIES(a_round_idle, clk, rst, state != ST_ROUND, round_count == '0, "round counter left running")
  `SHA1MD_ASSERT_IMPLIES(a_out_aligned, clk, rst, $rose(m_tvalid), fill_count == '0 && out_idx == '0, "digest started on an unfinished block")
  `SHA1MD_ASSERT_IMPLIES(a_out_bound, clk, rst, m_tvalid, out_idx <= WORD_LAST, "digest word index out of range")

endmodule

>>> src/sha1md_sched.sv
// Message schedule: a sixteen-word window that takes block words and expands W.
module sha1md_sched
  import sha1md_pkg::*;
(
  input  logic  clk,
  input  logic  push,
  input  word_t push_word,
  input  logic  step,
  output word_t w_cur
);

  word_t win [16];
  word_t w_new;
  word_t mix;

  assign mix   = win[13] ^ win[8] ^ win[2] ^ win[0];
  assign w_new = {mix[30:0], mix[31]};
  assign w_cur = win[0];

  always_ff @(posedge clk) begin
    if (push || step) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= push ? push_word : w_new;
    end
  end

endmodule

>>> src/sha1md_round.sv
// Shared round unit: working registers a to e and one SHA-1 round per step.
module sha1md_round
  import sha1md_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   load,
  input  logic   step,
  input  stage_t stage,
  input  hash_t  chain,
  input  word_t  w,
  output hash_t  regs
);

  word_t a, b, c, d, e;
  word_t f, k, t;

  assign a = regs[0];
  assign b = regs[1];
  assign c = regs[2];
  assign d = regs[3];
  assign e = regs[4];

  always_comb begin
    case (stage)
      STAGE_CH: begin
        f = (b & c) | (~b & d);
        k = K_CH;
      end
      STAGE_PAR1: begin
        f = b ^ c ^ d;
        k = K_PAR1;
      end
      STAGE_MAJ: begin
        f = (b & c) | (b & d) | (c & d);
        k = K_MAJ;
      end
      default: begin
        f = b ^ c ^ d;
        k = K_PAR2;
      end
    endcase
  end

  assign t = {a[26:0], a[31:27]} + f + e + k + w;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs <= '0;
    end else if (load) begin
      regs <= chain;
    end else if (step) begin
      regs <= {d, c, {b[1:0], b[31:2]}, a, t};
    end
  end

endmodule
